### rtl/spid_pkg.sv
// shared types, constants and codes for the speed pid block
package spid_pkg;

    localparam int PERIOD_STEPS = 16;

    localparam int DOWNHILL_SETPOINT = 70;
    localparam int KI_WINDOW = 50;
    localparam int SUM_LIMIT = 500;
    localparam int DRIVE_LIMIT = 1000;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] REG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] REG_GAIN_P       = 2'd1;
    localparam logic [1:0] REG_GAIN_I       = 2'd2;
    localparam logic [1:0] REG_GAIN_D       = 2'd3;

    typedef logic [1:0] cfg_index_t;
    typedef logic [8:0] cfg_data_t;
    typedef logic [8:0] target_t;
    typedef logic [7:0] gain_t;
    typedef logic signed [9:0] speed_t;
    typedef logic [3:0] phase_t;
    typedef logic signed [10:0] drive_t;
    typedef logic signed [10:0] error_t;
    typedef logic signed [9:0] error_sum_t;
    typedef logic signed [20:0] term_t;
    typedef logic signed [21:0] delta_t;

endpackage

### rtl/speed_pid_with_smoothed_output.sv
// speed pid controller with integral separation and interpolated drive output
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid in_ready opcode left_speed right_speed   | in
//          | downhill_active period_phase                      |
//  out     | out_valid out_ready drive                         | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data            | in
//
//  one item per cycle while no tick stalls: an item is held in the input register,
//  then the update math (three parallel multiplies and a sum) or the tick
//  interpolation runs in one pass into the state or the result register
//  drive is registered as the tick leaves the input register; updates give no item
//  reset clears gains, setpoint and all controller state
//  a tick held by a stalled out channel blocks the input register; cfg always ready
module speed_pid_with_smoothed_output (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  spid_pkg::speed_t     left_speed,
    input  spid_pkg::speed_t     right_speed,
    input  logic                 downhill_active,
    input  spid_pkg::phase_t     period_phase,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spid_pkg::drive_t     drive,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  spid_pkg::cfg_index_t cfg_index,
    input  spid_pkg::cfg_data_t  cfg_data
);
    import spid_pkg::*;

    target_t    target_speed_reg;
    gain_t      gain_p_reg;
    gain_t      gain_i_reg;
    gain_t      gain_d_reg;

    logic       in_valid_reg;
    logic       opcode_reg;
    speed_t     left_reg;
    speed_t     right_reg;
    logic       downhill_reg;
    phase_t     phase_reg;

    error_t     last_error_reg;
    error_sum_t error_sum_reg;
    term_t      prev_pid_term_reg;
    delta_t     pid_delta_reg;

    logic       out_valid_reg;
    drive_t     drive_reg;
    drive_t     drive_next;

    logic       stage_fire;
    logic       update_fire;
    logic       tick_fire;

    logic signed [10:0] pair_sum;
    logic signed [10:0] pair_round;
    speed_t             avg_speed;
    logic signed [9:0]  setpoint;
    error_t             error_w;
    logic signed [11:0] sum_raw;
    error_sum_t         error_sum_next;
    logic signed [11:0] error_diff;
    logic               ki_on;
    logic signed [19:0] p_prod;
    logic signed [20:0] d_prod;
    logic signed [18:0] i_prod;
    term_t              term_w;
    logic signed [21:0] current_wide;
    term_t              current_w;
    delta_t             delta_next;

    logic signed [21:0] step_w;
    logic signed [27:0] scaled_w;
    logic signed [28:0] interp_w;

    // handshakes
    assign stage_fire  = in_valid_reg && (opcode_reg == OP_UPDATE || !out_valid_reg || out_ready);
    assign update_fire = stage_fire && opcode_reg == OP_UPDATE;
    assign tick_fire   = stage_fire && opcode_reg == OP_TICK;
    assign in_ready    = !in_valid_reg || stage_fire;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;

    // update path
    assign pair_sum   = {left_reg[9], left_reg} + {right_reg[9], right_reg};
    assign pair_round = pair_sum + {10'd0, pair_sum[10]};
    assign avg_speed  = pair_round[10:1];
    assign setpoint   = downhill_reg ? 10'(DOWNHILL_SETPOINT) : {1'b0, target_speed_reg};
    assign error_w    = {setpoint[9], setpoint} - {avg_speed[9], avg_speed};

    assign sum_raw = {{2{error_sum_reg[9]}}, error_sum_reg} + {error_w[10], error_w};

    always_comb
    begin
        if (sum_raw > 12'(SUM_LIMIT))
        begin
            error_sum_next = 10'(SUM_LIMIT);
        end
        else if (sum_raw < -12'(SUM_LIMIT))
        begin
            error_sum_next = -10'(SUM_LIMIT);
        end
        else
        begin
            error_sum_next = sum_raw[9:0];
        end
    end

    assign error_diff = {error_w[10], error_w} - {last_error_reg[10], last_error_reg};
    assign ki_on      = (error_w <= 11'(KI_WINDOW)) && (error_w >= -11'(KI_WINDOW));

    assign p_prod = $signed({1'b0, gain_p_reg}) * error_w;
    assign d_prod = $signed({1'b0, gain_d_reg}) * error_diff;
    assign i_prod = ki_on ? $signed({1'b0, gain_i_reg}) * error_sum_next : 19'sd0;

    assign term_w = {p_prod[19], p_prod} + d_prod + {{2{i_prod[18]}}, i_prod};

    assign current_wide = {prev_pid_term_reg[20], prev_pid_term_reg} + pid_delta_reg;
    assign current_w    = current_wide[20:0];
    assign delta_next   = {term_w[20], term_w} - {current_w[20], current_w};

    // tick path
    assign step_w   = 22'(pid_delta_reg / PERIOD_STEPS);
    assign scaled_w = step_w * $signed({1'b0, {1'b0, phase_reg} + 5'd1});
    assign interp_w = {{8{prev_pid_term_reg[20]}}, prev_pid_term_reg}
                    + {scaled_w[27], scaled_w};

    always_comb
    begin
        if (interp_w > 29'(DRIVE_LIMIT))
        begin
            drive_next = 11'(DRIVE_LIMIT);
        end
        else if (interp_w < -29'(DRIVE_LIMIT))
        begin
            drive_next = -11'(DRIVE_LIMIT);
        end
        else
        begin
            drive_next = interp_w[10:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= '0;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_SPEED: target_speed_reg <= cfg_data;
                REG_GAIN_P:       gain_p_reg       <= cfg_data[7:0];
                REG_GAIN_I:       gain_i_reg       <= cfg_data[7:0];
                REG_GAIN_D:       gain_d_reg       <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg   <= opcode;
            left_reg     <= left_speed;
            right_reg    <= right_speed;
            downhill_reg <= downhill_active;
            phase_reg    <= period_phase;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg    <= '0;
            error_sum_reg     <= '0;
            prev_pid_term_reg <= '0;
            pid_delta_reg     <= '0;
        end
        else if (update_fire)
        begin
            last_error_reg    <= error_w;
            error_sum_reg     <= error_sum_next;
            prev_pid_term_reg <= current_w;
            pid_delta_reg     <= delta_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            drive_reg <= drive_next;
        end
    end

    // checks
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (error_sum_reg <= 10'(SUM_LIMIT)) && (error_sum_reg >= -10'(SUM_LIMIT)))
        else $error("error sum left its clamp window");

    a_drive_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg <= 11'(DRIVE_LIMIT)) && (drive_reg >= -11'(DRIVE_LIMIT)))
        else $error("drive item outside saturation limits");

    a_state_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        !update_fire |=> $stable(pid_delta_reg) && $stable(prev_pid_term_reg))
        else $error("controller state changed without an update item");

    a_tick_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && opcode_reg == OP_TICK && !tick_fire) |=> in_valid_reg && !in_ready
            || (in_valid_reg && $stable(opcode_reg)))
        else $error("stalled tick item dropped from the input register");

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the speed pid block with smoothed drive output
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spid_pkg::*;

    localparam int ITEMS_PER_SETTING = 116;
    localparam int NUM_SETTINGS      = 8;
    localparam int SETTLE_CYCLES     = 6;
    localparam int HOLD_CYCLES       = 90;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int DIR_ROWS          = 32;

    typedef enum logic [1:0] {ROW_UPDATE, ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        speed_t     l;
        speed_t     r;
        logic       dh;
        phase_t     ph;
        cfg_index_t idx;
        cfg_data_t  data;
        logic       has_exp;
        drive_t     exp_drive;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = OP_UPDATE;
    speed_t     left_speed = '0;
    speed_t     right_speed = '0;
    logic       downhill_active = 1'b0;
    phase_t     period_phase = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    drive_t     drive;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_TARGET_SPEED;
    cfg_data_t  cfg_data = '0;

    // controller state and registers as seen by the predictor
    target_t    setpoint_reg;
    gain_t      kp;
    gain_t      ki;
    gain_t      kd;
    error_t     prev_err;
    error_sum_t err_total;
    term_t      prev_term;
    delta_t     term_step;

    drive_t     drive_q[$];
    stim_row_t  dir_rows[DIR_ROWS];

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int mismatch_count = 0;
    int checked_count = 0;
    int update_count = 0;
    int tick_count = 0;
    int cfg_count = 0;
    int cycle_count = 0;

    speed_pid_with_smoothed_output u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .left_speed      (left_speed),
        .right_speed     (right_speed),
        .downhill_active (downhill_active),
        .period_phase    (period_phase),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive           (drive),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void apply_update(speed_t l, speed_t r, logic dh);
        int avg;
        int sp;
        int err;
        int acc;
        int term;
        int cur;
        avg = (int'(l) + int'(r)) / 2;
        sp = dh ? DOWNHILL_SETPOINT : int'(setpoint_reg);
        err = sp - avg;
        acc = int'(err_total) + err;
        if (acc > SUM_LIMIT)
            acc = SUM_LIMIT;
        else if (acc < -SUM_LIMIT)
            acc = -SUM_LIMIT;
        term = int'(kp) * err + int'(kd) * (err - int'(prev_err));
        if (err <= KI_WINDOW && err >= -KI_WINDOW)
            term += int'(ki) * acc;
        cur = int'(prev_term) + int'(term_step);
        prev_term = term_t'(cur);
        term_step = delta_t'(term - cur);
        prev_err = error_t'(err);
        err_total = error_sum_t'(acc);
    endfunction

    function automatic drive_t smoothed_drive(phase_t ph);
        int step;
        int d;
        step = int'(term_step) / PERIOD_STEPS;
        d = int'(prev_term) + step * (int'(ph) + 1);
        if (d > DRIVE_LIMIT)
            d = DRIVE_LIMIT;
        else if (d < -DRIVE_LIMIT)
            d = -DRIVE_LIMIT;
        return drive_t'(d);
    endfunction

    function automatic speed_t clip_speed(int v);
        if (v > 511)
            v = 511;
        else if (v < -512)
            v = -512;
        return speed_t'(v);
    endfunction

    function automatic stim_row_t row_update(int l, int r, logic dh);
        stim_row_t row;
        row = '0;
        row.kind = ROW_UPDATE;
        row.l = speed_t'(l);
        row.r = speed_t'(r);
        row.dh = dh;
        return row;
    endfunction

    function automatic stim_row_t row_tick(int ph);
        stim_row_t row;
        row = '0;
        row.kind = ROW_TICK;
        row.ph = phase_t'(ph);
        return row;
    endfunction

    function automatic stim_row_t row_tick_exp(int ph, int d);
        stim_row_t row;
        row = row_tick(ph);
        row.has_exp = 1'b1;
        row.exp_drive = drive_t'(d);
        return row;
    endfunction

    function automatic stim_row_t row_cfg(cfg_index_t idx, int data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = cfg_data_t'(data);
        return row;
    endfunction

    task automatic send_item(logic op, speed_t l, speed_t r, logic dh, phase_t ph,
                             logic has_exp, drive_t exp_drive);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        left_speed <= l;
        right_speed <= r;
        downhill_active <= dh;
        period_phase <= ph;
        do @(posedge clk); while (!in_ready);
        if (op == OP_TICK)
        begin
            drive_q.push_back(has_exp ? exp_drive : smoothed_drive(ph));
            tick_count++;
        end
        else
        begin
            apply_update(l, r, dh);
            update_count++;
        end
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            REG_TARGET_SPEED: setpoint_reg = target_t'(data);
            REG_GAIN_P:       kp = gain_t'(data);
            REG_GAIN_I:       ki = gain_t'(data);
            REG_GAIN_D:       kd = gain_t'(data);
            default:          ;
        endcase
        cfg_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering items and let every pending drive item come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        drive_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (drive_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected drive item %0d with nothing pending", drive);
            end
            else
            begin
                want = drive_q.pop_front();
                checked_count++;
                if (drive !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("drive mismatch: expected %0d, got %0d", want, drive);
                end
            end
        end
    end

    initial
    begin : stimulus
        int first;
        int sp;
        int base;
        int dev;
        int data;
        cfg_index_t idx;
        logic op;
        logic dh;
        speed_t l;
        speed_t r;
        phase_t ph;

        setpoint_reg = '0;
        kp = '0;
        ki = '0;
        kd = '0;
        prev_err = '0;
        err_total = '0;
        prev_term = '0;
        term_step = '0;

        dir_rows = '{
            row_tick_exp(0, 0),
            row_update(400, 400, 1'b0),
            row_tick_exp(15, 0),
            row_update(-512, -512, 1'b1),
            row_tick_exp(7, 0),
            row_cfg(REG_TARGET_SPEED, 511),
            row_cfg(REG_GAIN_P, 255),
            row_cfg(REG_GAIN_I, 255),
            row_cfg(REG_GAIN_D, 255),
            row_update(-400, -400, 1'b0),
            row_tick_exp(15, DRIVE_LIMIT),
            row_tick(0),
            row_update(400, 400, 1'b1),
            row_tick_exp(15, -DRIVE_LIMIT),
            row_cfg(REG_TARGET_SPEED, 100),
            row_cfg(REG_GAIN_P, 1),
            row_cfg(REG_GAIN_I, 2),
            row_cfg(REG_GAIN_D, 3),
            row_update(50, 50, 1'b0),
            row_tick(0),
            row_update(49, 50, 1'b0),
            row_tick(15),
            row_update(120, 120, 1'b1),
            row_update(121, 122, 1'b1),
            row_tick(8),
            row_update(1, -2, 1'b0),
            row_update(-3, 0, 1'b0),
            row_tick(3),
            row_update(511, 511, 1'b0),
            row_update(-512, 511, 1'b0),
            row_tick(15),
            row_tick(1)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
            begin
                if (k == 0 || dir_rows[k - 1].kind != ROW_CFG)
                    drain();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end
            else
                send_item(dir_rows[k].kind == ROW_TICK ? OP_TICK : OP_UPDATE,
                          dir_rows[k].l, dir_rows[k].r, dir_rows[k].dh, dir_rows[k].ph,
                          dir_rows[k].has_exp, dir_rows[k].exp_drive);
        end

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain();
            idle_on = (p != 4);
            first = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
            begin
                idx = cfg_index_t'((first + k) % 4);
                if (idx == REG_TARGET_SPEED)
                    data = (p == 0) ? 511 : (p == 1) ? 0 : $urandom_range(0, 511);
                else if (p == 0)
                    data = 255;
                else if (p == 1)
                    data = 0;
                else if ($urandom_range(0, 3) == 0)
                    data = $urandom_range(0, 511);
                else
                    data = $urandom_range(0, 3);
                write_reg(idx, cfg_data_t'(data));
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (p == 2 && n == 40)
                    hold_req = 1'b1;
                if (p == 3 && n == 50)
                    drain();
                op = 1'($urandom_range(0, 1));
                l = speed_t'($urandom);
                r = speed_t'($urandom);
                dh = 1'($urandom_range(0, 1));
                ph = phase_t'($urandom);
                // most updates land near the setpoint so the integral window is hit
                if (op == OP_UPDATE && $urandom_range(0, 9) < 6)
                begin
                    sp = dh ? DOWNHILL_SETPOINT : int'(setpoint_reg);
                    base = sp + int'($urandom_range(0, 120)) - 60;
                    dev = int'($urandom_range(0, 6)) - 3;
                    l = clip_speed(base + dev);
                    r = clip_speed(base - dev);
                end
                send_item(op, l, r, dh, ph, 1'b0, '0);
            end
        end
        drain();

        $display("covered %0d control updates and %0d output ticks, %0d drive items checked",
                 update_count, tick_count, checked_count);
        $display("%0d register writes over %0d settings incl. all-max and all-zero, %0d mismatches",
                 cfg_count, NUM_SETTINGS + 2, mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### speed_pid_with_smoothed_output.f
rtl/spid_pkg.sv
rtl/speed_pid_with_smoothed_output.sv
tb/sv/testbench.sv
